// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable priority queue
// Request and response words, operation and status codes, control commands.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   localparam int PRIO_BITS     = 16;
   localparam int TAG_WORD_BITS = 32;
   localparam int FILL_BITS     = 5;

   typedef struct packed {
      logic                     func;
      logic [PRIO_BITS-1:0]     priority_req;
      logic [TAG_WORD_BITS-1:0] item_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [PRIO_BITS-1:0]     out_priority;
      logic [TAG_WORD_BITS-1:0] out_tag;
      logic [FILL_BITS-1:0]     fill_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request word
      logic commit;   // execute captured request, load response register
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Accepts one request word, then commits it once the response register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output spq_pkg::ctrl_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/spq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath: sorted entry row and response register
// Each slot compares its priority with the new one; insert and remove shift
// the row by one slot in a single commit.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH    = 16,
   parameter int TAG_BITS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire spq_pkg::ctrl_cmd_type cmd,
   input  wire spq_pkg::req_type      req_word,
   output spq_pkg::rsp_type           rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PB    = spq_pkg::PRIO_BITS;

   spq_pkg::req_type req_ff;
   spq_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PB-1:0]       prio_ff [DEPTH];
   logic [TAG_BITS-1:0] tag_ff  [DEPTH];
   logic [PB-1:0]       prio_in [DEPTH];
   logic [TAG_BITS-1:0] tag_in  [DEPTH];

   logic [DEPTH-1:0]    le;          // slot holds an entry <= new priority
   logic [TAG_BITS-1:0] tag_new;
   logic [spq_pkg::TAG_WORD_BITS-1:0] head_tag;
   logic                is_insert, ins_go, rem_go;
   logic                q_full, q_empty;
   logic [1:0]          status;

   generate
      if (TAG_BITS >= spq_pkg::TAG_WORD_BITS) begin : g_tag_wide
         assign tag_new  = TAG_BITS'(req_ff.item_tag);
         assign head_tag = tag_ff[0][spq_pkg::TAG_WORD_BITS-1:0];
      end else begin : g_tag_narrow
         assign tag_new  = req_ff.item_tag[TAG_BITS-1:0];
         assign head_tag = spq_pkg::TAG_WORD_BITS'(tag_ff[0]);
      end
   endgenerate

   assign is_insert = (req_ff.func == spq_pkg::FUNC_INSERT);
   assign q_full    = (count_ff == CNT_W'(DEPTH));
   assign q_empty   = (count_ff == '0);

   always_comb begin
      if (is_insert) begin
         priority if (req_ff.priority_req == '0) status = spq_pkg::ST_ZERO;
         else if (q_full)                         status = spq_pkg::ST_FULL;
         else                                     status = spq_pkg::ST_OK;
      end else begin
         status = q_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
   end

   assign ins_go = cmd.commit && is_insert  && (status == spq_pkg::ST_OK);
   assign rem_go = cmd.commit && !is_insert && (status == spq_pkg::ST_OK);

   // per-slot compare and next value
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_slot
         logic prev_le;
         logic [PB-1:0]       prev_prio, next_prio;
         logic [TAG_BITS-1:0] prev_tag,  next_tag;

         assign le[g] = (CNT_W'(g) < count_ff) && (prio_ff[g] <= req_ff.priority_req);

         if (g == 0) begin : g_first
            assign prev_le   = 1'b1;
            assign prev_prio = prio_ff[g];
            assign prev_tag  = tag_ff[g];
         end else begin : g_mid
            assign prev_le   = le[g-1];
            assign prev_prio = prio_ff[g-1];
            assign prev_tag  = tag_ff[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign next_prio = prio_ff[g];
            assign next_tag  = tag_ff[g];
         end else begin : g_inner
            assign next_prio = prio_ff[g+1];
            assign next_tag  = tag_ff[g+1];
         end

         always_comb begin
            prio_in[g] = prio_ff[g];
            tag_in[g]  = tag_ff[g];
            if (ins_go && !le[g]) begin
               if (prev_le) begin
                  prio_in[g] = req_ff.priority_req;
                  tag_in[g]  = tag_new;
               end else begin
                  prio_in[g] = prev_prio;
                  tag_in[g]  = prev_tag;
               end
            end else if (rem_go) begin
               prio_in[g] = next_prio;
               tag_in[g]  = next_tag;
            end
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ins_go) begin
         count_in = count_ff + 1'b1;
      end else if (rem_go) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      if (cmd.commit) begin
         rsp_in.status       = status;
         rsp_in.out_priority = rem_go ? prio_ff[0] : '0;
         rsp_in.out_tag      = rem_go ? head_tag : '0;
         rsp_in.fill_count   = spq_pkg::FILL_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < DEPTH; i++) begin
         prio_ff[i] <= prio_in[i];
         tag_ff[i]  <= tag_in[i];
      end
   end

   assign rsp_word = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_go |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow count");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      rem_go |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not shrink count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> prio_ff[0] <= prio_ff[1])
      else $error("head entries out of order");

endmodule
`default_nettype wire

// ----- rtl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, lowest value served first
// Insert and remove-head operations on a sorted row of DEPTH entries;
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Each request word is an insert (priority, tag) or a remove of the head entry,
// and each produces exactly one response word carrying a status (ok, empty on
// remove, full on insert, zero priority on insert), the removed priority and
// tag (zero when nothing was removed) and the fill count after the operation.
// An operation first captures the request word, then commits it; in the commit,
// every slot compares its priority with the new one in parallel and the whole
// row shifts by one slot. The response sits in an output register, so the next
// request is taken while a response still waits; the commit cycle stalls only
// while that register is still full. Tags are kept to TAG_BITS bits. The
// entry row has no reset of its own; only the fill count is cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
   parameter int DEPTH    = 16,
   parameter int TAG_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire spq_pkg::req_type req_word,
   // response channel
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output spq_pkg::rsp_type      rsp_word
);

   // load / commit strobes from sequencer to datapath
   spq_pkg::ctrl_cmd_type cmd;

   // sequencer: capture, then commit when the response register can take it
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // sorted entry row, fill count and response register
   spq_datapath #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire
